// ----- rtl/pmsc_pkg.sv -----
// Shared constants and types for the pilot median state classifier.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package pmsc_pkg;

  localparam int unsigned WINDOW   = 7;
  localparam int unsigned DECIMATE = 1;

  localparam int unsigned AdcW     = 12;
  localparam int unsigned UsW      = 16;
  localparam int unsigned SpuW     = 8;
  localparam int unsigned ClsW     = 3;

  localparam int unsigned RankW    = $clog2(WINDOW + 1);
  localparam int unsigned PosW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned PhaseW   = (DECIMATE > 1) ? $clog2(DECIMATE) : 1;
  localparam int unsigned StepW    = 4;

  typedef logic [AdcW-1:0] sample_t;

  localparam logic [ClsW-1:0] CLS_NONE = 3'd0;
  localparam logic [ClsW-1:0] CLS_A    = 3'd1;
  localparam logic [ClsW-1:0] CLS_B    = 3'd2;
  localparam logic [ClsW-1:0] CLS_C    = 3'd3;
  localparam logic [ClsW-1:0] CLS_EF   = 3'd4;
  localparam logic [ClsW-1:0] CLS_INIT = 3'd7;

  localparam logic [SpuW-1:0] SPU_RESET   = 8'd10;
  localparam logic [UsW-1:0]  STALE_RESET = 16'd85;

  localparam logic [0:0] REG_SPU   = 1'b0;
  localparam logic [0:0] REG_STALE = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/pmsc_if.sv -----
// Valid/ready channel interfaces for samples in and classified results out.
// Depends on pmsc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pmsc_in_if
  import pmsc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [AdcW-1:0] adc_value;
  logic            edge_timed;
  logic [UsW-1:0]  elapsed_us;

  modport source (output valid, adc_value, edge_timed, elapsed_us, input ready);
  modport sink   (input valid, adc_value, edge_timed, elapsed_us, output ready);
endinterface

interface pmsc_out_if
  import pmsc_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [AdcW-1:0] median_value;
  logic [ClsW-1:0] level_class;
  logic            class_changed;

  modport source (output valid, median_value, level_class, class_changed, input ready);
  modport sink   (input valid, median_value, level_class, class_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/pmsc_median.sv -----
// Bit-serial median selector: radix select, MSB first, one bit per cycle.
// Depends on pmsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pmsc_median
  import pmsc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire sample_t ring_i [WINDOW],
  output logic         done_o,
  output sample_t      median_o
);

  sample_t                work_q [WINDOW];
  sample_t                work_d [WINDOW];
  logic [WINDOW-1:0]      cand_q, cand_d;
  logic [WINDOW-1:0]      msb;
  logic [WINDOW-1:0]      zero_cand;
  logic [RankW-1:0]       rank_q, rank_d;
  logic [RankW-1:0]       c0;
  logic                   bit_val;
  logic                   busy_q;
  logic [StepW-1:0]       step_q;
  sample_t                res_q;

  always_comb begin
    c0 = '0;
    for (int i = 0; i < WINDOW; i++) begin
      msb[i]       = work_q[i][AdcW-1];
      zero_cand[i] = cand_q[i] & ~work_q[i][AdcW-1];
      c0           = c0 + RankW'(zero_cand[i]);
    end
    bit_val = (rank_q >= c0);
    if (bit_val) begin
      rank_d = rank_q - c0;
      cand_d = cand_q & msb;
    end else begin
      rank_d = rank_q;
      cand_d = zero_cand;
    end
    for (int i = 0; i < WINDOW; i++) begin
      work_d[i] = {work_q[i][AdcW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(AdcW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= ring_i;
      cand_q <= '1;
      rank_q <= RankW'(WINDOW / 2);
      res_q  <= '0;
    end else if (busy_q) begin
      work_q <= work_d;
      cand_q <= cand_d;
      rank_q <= rank_d;
      res_q  <= {res_q[AdcW-2:0], bit_val};
    end
  end

  assign median_o = res_q;

endmodule

`default_nettype wire

// ----- rtl/pilot_median_state_classifier.sv -----
// Pilot median state classifier top level.
// Depends on pmsc_pkg, pmsc_if (pmsc_in_if, pmsc_out_if) and pmsc_median.
//
// Usage:
//   sample_i carries one converter tick per transaction (adc_value,
//   edge_timed, elapsed_us); result_o carries median_value, level_class
//   and class_changed. Both use valid/ready.
//   The APB-style port holds samples_per_update at 0x0 and stale_limit_us
//   at 0x4; write only while the block is idle.
//   One transaction at a time. A decimated tick runs the bit-serial delay
//   compare, then a ring update state and back to ready; a dropped sample
//   returns to ready straight from the compare. A skipped tick goes only
//   through the ring update state. A tick that triggers an evaluation then
//   selects the median one bit per cycle over its 12 bits, then classifies
//   and registers it before it moves into the output register.
//   Reset clears the ring, its fill level and write position and the tick
//   count, sets the last class to CLS_INIT and loads the register defaults.
//   Results sit in an output register; a stalled receiver only blocks the
//   block once a second result is ready while the first is still held.
`timescale 1ns / 1ps
`default_nettype none

module pilot_median_state_classifier
  import pmsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  pmsc_in_if.sink          sample_i,
  pmsc_out_if.source       result_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MST  = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_CLS  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [SpuW-1:0]  spu_q;
  logic [UsW-1:0]   stale_q;

  sample_t          ring_q [WINDOW];
  logic [PosW-1:0]  pos_q;
  logic [RankW-1:0] fill_q, fill_d;
  logic [SpuW-1:0]  tick_q, tick_inc;
  logic [PhaseW-1:0] phase_q;
  logic [ClsW-1:0]  last_q;

  sample_t          adc_q;
  logic             timed_q;
  logic             write_q;
  logic [UsW-1:0]   el_q;
  logic [UsW-1:0]   lim_q;
  logic             gt_q, gt_d;
  logic [StepW-1:0] step_q;

  logic             med_start;
  logic             med_done;
  sample_t          med_val;
  sample_t          med_q;
  logic [ClsW-1:0]  cls_q, cls_d;

  logic             out_valid_q;
  sample_t          out_val_q;
  logic [ClsW-1:0]  out_cls_q;
  logic             out_chg_q;

  logic             accept;
  logic             cfg_wr;
  logic             drop;
  logic             eval;
  logic             out_free;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign prdata   = (paddr[2] == REG_STALE) ? {16'd0, stale_q} : {24'd0, spu_q};

  assign sample_i.ready = (state_q == S_IDLE);
  assign accept         = sample_i.valid & sample_i.ready;

  assign gt_d     = (el_q[0] != lim_q[0]) ? (el_q[0] & ~lim_q[0]) : gt_q;
  assign drop     = (adc_q == '0) | (timed_q & gt_d);
  assign tick_inc = tick_q + 1'b1;
  assign fill_d   = (write_q && fill_q < RankW'(WINDOW)) ? fill_q + 1'b1 : fill_q;
  assign eval     = (tick_inc >= spu_q) && (fill_d == RankW'(WINDOW));
  assign med_start = (state_q == S_MST);
  assign out_free = ~out_valid_q | result_o.ready;

  always_comb begin
    cls_d = CLS_NONE;
    if (med_q > 12'd4000) begin
      cls_d = CLS_A;
    end else if (med_q inside {[12'd3501:12'd3799]}) begin
      cls_d = CLS_B;
    end else if (med_q inside {[12'd3051:12'd3349]}) begin
      cls_d = CLS_C;
    end else if (med_q inside {[12'd606:12'd904]}) begin
      cls_d = CLS_EF;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (phase_q == '0) ? S_CHK : S_UPD;
        end
      end
      S_CHK: begin
        if (step_q == StepW'(UsW - 1)) begin
          state_d = drop ? S_IDLE : S_UPD;
        end
      end
      S_UPD:   state_d = eval ? S_MST : S_IDLE;
      S_MST:   state_d = S_SEL;
      S_SEL:   state_d = med_done ? S_CLS : S_SEL;
      S_CLS:   state_d = S_OUT;
      S_OUT:   state_d = out_free ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      spu_q       <= SPU_RESET;
      stale_q     <= STALE_RESET;
      pos_q       <= '0;
      fill_q      <= '0;
      tick_q      <= '0;
      phase_q     <= '0;
      last_q      <= CLS_INIT;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == REG_SPU) begin
          spu_q <= pwdata[SpuW-1:0];
        end else begin
          stale_q <= pwdata[UsW-1:0];
        end
      end
      if (state_q == S_UPD) begin
        if (write_q) begin
          ring_q[pos_q] <= adc_q;
          pos_q         <= (pos_q == PosW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
          fill_q        <= fill_d;
        end
        if (tick_inc >= spu_q) begin
          tick_q  <= '0;
          phase_q <= '0;
        end else begin
          tick_q <= tick_inc;
          if (tick_inc == '0 || phase_q == PhaseW'(DECIMATE - 1)) begin
            phase_q <= '0;
          end else begin
            phase_q <= phase_q + 1'b1;
          end
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
        last_q      <= cls_q;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      adc_q   <= sample_i.adc_value;
      timed_q <= sample_i.edge_timed;
      el_q    <= sample_i.elapsed_us;
      lim_q   <= stale_q;
      write_q <= (phase_q == '0);
      gt_q    <= 1'b0;
      step_q  <= '0;
    end else if (state_q == S_CHK) begin
      el_q   <= {1'b0, el_q[UsW-1:1]};
      lim_q  <= {1'b0, lim_q[UsW-1:1]};
      gt_q   <= gt_d;
      step_q <= step_q + 1'b1;
    end
    if (state_q == S_SEL && med_done) begin
      med_q <= med_val;
    end
    if (state_q == S_CLS) begin
      cls_q <= cls_d;
    end
    if (state_q == S_OUT && out_free) begin
      out_val_q <= med_q;
      out_cls_q <= cls_q;
      out_chg_q <= (cls_q != last_q);
    end
  end

  pmsc_median u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (med_start),
    .ring_i   (ring_q),
    .done_o   (med_done),
    .median_o (med_val)
  );

  assign result_o.valid         = out_valid_q;
  assign result_o.median_value  = out_val_q;
  assign result_o.level_class   = out_cls_q;
  assign result_o.class_changed = out_chg_q;

endmodule

`default_nettype wire
